// File: rtl/core/bgt_pkg.sv
// ----------------------------------------------------------------------------
// bgt_pkg
// Shared types and codes of the breadth first search engine.
// ----------------------------------------------------------------------------
package bgt_pkg;

   typedef enum logic {
      OP_ADD = 1'b0,
      OP_RUN = 1'b1
   } opcode_type;

   typedef enum logic [1:0] {
      ST_STORED  = 2'd0,
      ST_VISITED = 2'd1,
      ST_FULL    = 2'd2,
      ST_RANGE   = 2'd3
   } status_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_ADD_RD_U,
      S_ADD_WR_U,
      S_ADD_RD_V,
      S_ADD_WR_V,
      S_POP,
      S_HEAD,
      S_LINK,
      S_ENTRY
   } state_type;

   localparam int unsigned VertexBits = 6;
   localparam int unsigned CountBits  = 7;
   localparam logic [2:0]  RegVertexCount = 3'd0;

   typedef struct packed {
      logic                  opcode;
      logic [VertexBits-1:0] first_vertex;
      logic [VertexBits-1:0] second_vertex;
   } req_type;

   typedef struct packed {
      logic [VertexBits-1:0] vertex_out;
      logic [1:0]            status;
      logic                  last;
   } rsp_type;

   typedef struct packed {
      logic head_rd;
      logic head_wr;
      logic ent_rd;
      logic ent_wr;
   } store_ctl_type;

endpackage

// File: rtl/core/bgt_edge_store.sv
// ----------------------------------------------------------------------------
// bgt_edge_store
// List heads and adjacency entries, registered reads.
// ----------------------------------------------------------------------------
module bgt_edge_store
   import bgt_pkg::*;
#(
   parameter int unsigned MAX_VERTICES = 64,
   parameter int unsigned MAX_EDGES    = 128
) (
   input  logic                  clock,
   input  logic                  reset,
   input  store_ctl_type         ctl,
   input  logic [$clog2(MAX_VERTICES)-1:0]  head_addr,
   input  logic [$clog2(2*MAX_EDGES+1)-1:0] head_wdata,
   output logic [$clog2(2*MAX_EDGES+1)-1:0] head_rdata,
   input  logic [$clog2(2*MAX_EDGES)-1:0]   ent_addr,
   input  logic [VertexBits-1:0]            ent_wtarget,
   input  logic [$clog2(2*MAX_EDGES+1)-1:0] ent_wlink,
   output logic [VertexBits-1:0]            ent_rtarget,
   output logic [$clog2(2*MAX_EDGES+1)-1:0] ent_rlink
);

   localparam int unsigned Slots = 2 * MAX_EDGES;
   localparam int unsigned PW    = $clog2(Slots + 1);

   logic [PW-1:0]           head_mem [MAX_VERTICES];
   logic [MAX_VERTICES-1:0] head_valid_ff;
   logic [PW-1:0]           head_q_ff;
   logic                    head_qv_ff;
   logic [VertexBits-1:0]   tgt_mem [Slots];
   logic [PW-1:0]           lnk_mem [Slots];
   logic [VertexBits-1:0]   tgt_q_ff;
   logic [PW-1:0]           lnk_q_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         head_valid_ff <= '0;
      end else if (ctl.head_wr) begin
         head_valid_ff[head_addr] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.head_wr) begin
         head_mem[head_addr] <= head_wdata;
      end
      if (ctl.head_rd) begin
         head_q_ff  <= head_mem[head_addr];
         head_qv_ff <= head_valid_ff[head_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.ent_wr) begin
         tgt_mem[ent_addr] <= ent_wtarget;
         lnk_mem[ent_addr] <= ent_wlink;
      end
      if (ctl.ent_rd) begin
         tgt_q_ff <= tgt_mem[ent_addr];
         lnk_q_ff <= lnk_mem[ent_addr];
      end
   end

   assign head_rdata  = head_qv_ff ? head_q_ff : '0;
   assign ent_rtarget = tgt_q_ff;
   assign ent_rlink   = lnk_q_ff;

endmodule

// File: rtl/core/bgt_seq.sv
// ----------------------------------------------------------------------------
// bgt_seq
// Sequencer: edge linking, visit queue, seen map and list walk.
// ----------------------------------------------------------------------------
module bgt_seq
   import bgt_pkg::*;
#(
   parameter int unsigned MAX_VERTICES = 64,
   parameter int unsigned MAX_EDGES    = 128
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  req_type               req_data,
   input  logic [CountBits-1:0]  vertex_count,
   output logic                  rsp_strobe,
   output rsp_type               rsp_data,
   output store_ctl_type         ctl,
   output logic [$clog2(MAX_VERTICES)-1:0]  head_addr,
   output logic [$clog2(2*MAX_EDGES+1)-1:0] head_wdata,
   input  logic [$clog2(2*MAX_EDGES+1)-1:0] head_rdata,
   output logic [$clog2(2*MAX_EDGES)-1:0]   ent_addr,
   output logic [VertexBits-1:0]            ent_wtarget,
   output logic [$clog2(2*MAX_EDGES+1)-1:0] ent_wlink,
   input  logic [VertexBits-1:0]            ent_rtarget,
   input  logic [$clog2(2*MAX_EDGES+1)-1:0] ent_rlink
);

   localparam int unsigned Slots = 2 * MAX_EDGES;
   localparam int unsigned PW    = $clog2(Slots + 1);
   localparam int unsigned EW    = $clog2(Slots);
   localparam int unsigned VW    = $clog2(MAX_VERTICES);
   localparam int unsigned QW    = $clog2(MAX_VERTICES + 1);
   localparam logic [PW-1:0]        FullAt  = PW'(Slots - 2);
   localparam logic [QW-1:0]        QDepth  = QW'(MAX_VERTICES);
   localparam logic [CountBits-1:0] MaxCnt  = CountBits'(MAX_VERTICES);

   state_type               state_ff, state_in;
   req_type                 req_ff, req_in;
   logic [PW-1:0]           used_ff, used_in;
   logic [MAX_VERTICES-1:0] seen_ff, seen_in;
   logic [QW-1:0]           front_ff, front_in, rear_ff, rear_in;
   logic [VertexBits-1:0]   cur_ff, cur_in;
   logic                    strobe_ff, strobe_in;
   rsp_type                 rsp_ff, rsp_in;
   logic [VertexBits-1:0]   q_mem [MAX_VERTICES];
   logic [VertexBits-1:0]   q_rdata_ff;
   logic                    q_wr, q_rd;
   logic [VW-1:0]           q_waddr;
   logic [VertexBits-1:0]   q_wdata;

   logic [CountBits-1:0] eff;
   logic                 u_bad, v_bad, full, t_ok, walk_done;

   assign eff   = (vertex_count < MaxCnt) ? vertex_count : MaxCnt;
   assign u_bad = {1'b0, req_data.first_vertex} >= eff;
   assign v_bad = {1'b0, req_data.second_vertex} >= eff;
   assign full  = used_ff > FullAt;
   assign t_ok  = ({1'b0, ent_rtarget} < eff) && !seen_ff[ent_rtarget[VW-1:0]]
                  && (rear_ff < QDepth);
   assign walk_done = (state_ff == S_LINK) ? (head_rdata == '0) : (ent_rlink == '0);

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (start) begin
               if (req_data.opcode == OP_ADD) begin
                  if (!(u_bad || v_bad || full)) state_in = S_ADD_RD_U;
               end else if (!u_bad) begin
                  state_in = S_POP;
               end
            end
         end
         S_ADD_RD_U: state_in = S_ADD_WR_U;
         S_ADD_WR_U: state_in = S_ADD_RD_V;
         S_ADD_RD_V: state_in = S_ADD_WR_V;
         S_ADD_WR_V: state_in = S_IDLE;
         S_POP:      state_in = S_HEAD;
         S_HEAD:     state_in = S_LINK;
         S_LINK, S_ENTRY: begin
            if (!walk_done) state_in = S_ENTRY;
            else if (front_ff == rear_in) state_in = S_IDLE;
            else state_in = S_POP;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      req_in      = req_ff;
      used_in     = used_ff;
      seen_in     = seen_ff;
      front_in    = front_ff;
      rear_in     = rear_ff;
      cur_in      = cur_ff;
      strobe_in   = 1'b0;
      rsp_in      = rsp_ff;
      ctl         = '0;
      head_addr   = req_ff.first_vertex[VW-1:0];
      head_wdata  = used_ff + PW'(1);
      ent_addr    = used_ff[EW-1:0];
      ent_wtarget = req_ff.second_vertex;
      ent_wlink   = head_rdata;
      q_wr        = 1'b0;
      q_rd        = 1'b0;
      q_waddr     = rear_ff[VW-1:0];
      q_wdata     = ent_rtarget;
      case (state_ff)
         S_IDLE: begin
            if (start) begin
               req_in = req_data;
               rsp_in = '{vertex_out: '0, status: ST_STORED, last: 1'b1};
               if (req_data.opcode == OP_ADD) begin
                  if (u_bad || v_bad) begin
                     strobe_in     = 1'b1;
                     rsp_in.status = ST_RANGE;
                  end else if (full) begin
                     strobe_in     = 1'b1;
                     rsp_in.status = ST_FULL;
                  end
               end else if (u_bad) begin
                  strobe_in     = 1'b1;
                  rsp_in.status = ST_RANGE;
               end else begin
                  seen_in = '0;
                  seen_in[req_data.first_vertex[VW-1:0]] = 1'b1;
                  q_wr     = 1'b1;
                  q_waddr  = '0;
                  q_wdata  = req_data.first_vertex;
                  front_in = '0;
                  rear_in  = QW'(1);
               end
            end
         end
         S_ADD_RD_U: ctl.head_rd = 1'b1;
         S_ADD_WR_U: begin
            ctl.head_wr = 1'b1;
            ctl.ent_wr  = 1'b1;
            used_in     = used_ff + PW'(1);
         end
         S_ADD_RD_V: begin
            ctl.head_rd = 1'b1;
            head_addr   = req_ff.second_vertex[VW-1:0];
         end
         S_ADD_WR_V: begin
            ctl.head_wr = 1'b1;
            ctl.ent_wr  = 1'b1;
            head_addr   = req_ff.second_vertex[VW-1:0];
            ent_wtarget = req_ff.first_vertex;
            used_in     = used_ff + PW'(1);
            strobe_in   = 1'b1;
            rsp_in      = '{vertex_out: '0, status: ST_STORED, last: 1'b1};
         end
         S_POP: begin
            q_rd     = 1'b1;
            front_in = front_ff + QW'(1);
         end
         S_HEAD: begin
            cur_in      = q_rdata_ff;
            ctl.head_rd = 1'b1;
            head_addr   = q_rdata_ff[VW-1:0];
         end
         S_LINK, S_ENTRY: begin
            if (state_ff == S_ENTRY && t_ok) begin
               seen_in[ent_rtarget[VW-1:0]] = 1'b1;
               q_wr    = 1'b1;
               rear_in = rear_ff + QW'(1);
            end
            if (walk_done) begin
               strobe_in = 1'b1;
               rsp_in    = '{vertex_out: cur_ff, status: ST_VISITED,
                             last: (front_ff == rear_in)};
            end else begin
               ctl.ent_rd = 1'b1;
               ent_addr   = (state_ff == S_LINK) ? EW'(head_rdata - PW'(1))
                                                 : EW'(ent_rlink - PW'(1));
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (q_wr) begin
         q_mem[q_waddr] <= q_wdata;
      end
      if (q_rd) begin
         q_rdata_ff <= q_mem[front_ff[VW-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         used_ff   <= '0;
         seen_ff   <= '0;
         front_ff  <= '0;
         rear_ff   <= '0;
         strobe_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         used_ff   <= used_in;
         seen_ff   <= seen_in;
         front_ff  <= front_in;
         rear_ff   <= rear_in;
         strobe_ff <= strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff <= req_in;
      cur_ff <= cur_in;
      rsp_ff <= rsp_in;
   end

   assign busy       = (state_ff != S_IDLE);
   assign rsp_strobe = strobe_ff;
   assign rsp_data   = rsp_ff;

endmodule

// File: rtl/core/bfs_graph_traversal.sv
// ----------------------------------------------------------------------------
// bfs_graph_traversal
// Undirected graph breadth first search engine with an adjacency list store.
//
// A request is taken when start is high and busy is low. Opcode add links
// both endpoints and answers with one status result; opcode run walks breadth
// first from first_vertex and emits one result per visited vertex, last set
// on the final one. Results appear on rsp_data for one cycle with rsp_strobe
// and cannot be stalled.
// A rejected request answers in the cycle after it is taken. An add reads and
// writes the head of each endpoint in turn; a run pops each vertex, reads its
// head and walks its adjacency entries through the single registered read
// port of the entry store, and busy stays high throughout. vertex_count is to
// be written over the csr port while idle (not enforced), reset value 64.
// Reset empties every list and the edge store and returns to idle.
// ----------------------------------------------------------------------------
module bfs_graph_traversal
   import bgt_pkg::*;
#(
   parameter int unsigned MAX_VERTICES = 64,
   parameter int unsigned MAX_EDGES    = 128
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  req_type     req_data,
   output logic        rsp_strobe,
   output rsp_type     rsp_data,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   localparam int unsigned PW = $clog2(2 * MAX_EDGES + 1);
   localparam int unsigned EW = $clog2(2 * MAX_EDGES);
   localparam int unsigned VW = $clog2(MAX_VERTICES);

   logic [CountBits-1:0] vcount_ff, vcount_in;
   store_ctl_type        ctl;
   logic [VW-1:0]        head_addr;
   logic [PW-1:0]        head_wdata, head_rdata, ent_wlink, ent_rlink;
   logic [EW-1:0]        ent_addr;
   logic [VertexBits-1:0] ent_wtarget, ent_rtarget;

   always_comb begin
      vcount_in = vcount_ff;
      if (csr_psel && csr_penable && csr_pwrite && csr_paddr == RegVertexCount) begin
         vcount_in = csr_pwdata[CountBits-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vcount_ff <= CountBits'(64);
      end else begin
         vcount_ff <= vcount_in;
      end
   end

   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr == RegVertexCount) ? {25'd0, vcount_ff} : 32'd0;

   bgt_seq #(
      .MAX_VERTICES (MAX_VERTICES),
      .MAX_EDGES    (MAX_EDGES)
   ) u_seq (
      .clock        (clock),
      .reset        (reset),
      .start        (start),
      .busy         (busy),
      .req_data     (req_data),
      .vertex_count (vcount_ff),
      .rsp_strobe   (rsp_strobe),
      .rsp_data     (rsp_data),
      .ctl          (ctl),
      .head_addr    (head_addr),
      .head_wdata   (head_wdata),
      .head_rdata   (head_rdata),
      .ent_addr     (ent_addr),
      .ent_wtarget  (ent_wtarget),
      .ent_wlink    (ent_wlink),
      .ent_rtarget  (ent_rtarget),
      .ent_rlink    (ent_rlink)
   );

   bgt_edge_store #(
      .MAX_VERTICES (MAX_VERTICES),
      .MAX_EDGES    (MAX_EDGES)
   ) u_store (
      .clock        (clock),
      .reset        (reset),
      .ctl          (ctl),
      .head_addr    (head_addr),
      .head_wdata   (head_wdata),
      .head_rdata   (head_rdata),
      .ent_addr     (ent_addr),
      .ent_wtarget  (ent_wtarget),
      .ent_wlink    (ent_wlink),
      .ent_rtarget  (ent_rtarget),
      .ent_rlink    (ent_rlink)
   );

endmodule
